FILE: rtl/core/lalc_pkg.sv
// Shared types and constants for the line assembler ARQ link controller.
// Used by the configuration, controller, datapath and top-level modules.
// No dependencies.
package lalc_pkg;

  // Default depth of one line buffer.
  localparam int MAX_LINE_DEF = 32;

  // Configuration register widths and reset values.
  localparam int MR_W  = 4;
  localparam int LL_W  = 6;
  localparam int MIC_W = 4;

  localparam logic [MR_W-1:0]  RETRY_BUDGET_RST = MR_W'(3);
  localparam logic [LL_W-1:0]  LINE_LIMIT_RST   = LL_W'(26);
  localparam logic [MIC_W-1:0] MIC_LENGTH_RST   = MIC_W'(4);

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_RETRY_BUDGET = 2'd0;
  localparam logic [1:0] REG_LINE_LIMIT   = 2'd1;
  localparam logic [1:0] REG_MIC_LENGTH   = 2'd2;

  // Frame and serial constants.
  localparam logic [7:0] FRAME_HEADER = 8'h02;
  localparam logic [7:0] CR_CHAR      = 8'h0D;

  // Input event kinds.
  localparam logic [2:0] REQ_BYTE    = 3'd0;
  localparam logic [2:0] REQ_TICK    = 3'd1;
  localparam logic [2:0] REQ_RX_OK   = 3'd2;
  localparam logic [2:0] REQ_RX_FAIL = 3'd3;
  localparam logic [2:0] REQ_TX_DONE = 3'd4;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_LISTEN = 2'd1,
    CMD_SEND   = 2'd2
  } radio_cmd_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       take_byte;
    logic       stream_start;
    logic       load_one;
    logic       load_stream;
    radio_cmd_t res_cmd;
    logic       res_nack;
    logic       res_deliver;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic stream_last;
    logic line_done;
  } dp_stat_t;

endpackage

FILE: rtl/core/lalc_cfg.sv
// APB-style configuration registers of the line assembler ARQ link controller.
// Depends on lalc_pkg for register indexes, widths and reset values.
module lalc_cfg (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [3:0]               cfg_paddr,
  input  logic [31:0]              cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready,
  output logic [lalc_pkg::MR_W-1:0]  retry_budget,
  output logic [lalc_pkg::LL_W-1:0]  line_limit,
  output logic [lalc_pkg::MIC_W-1:0] mic_length
);
  import lalc_pkg::*;

  logic [MR_W-1:0]  retry_budget_r;
  logic [LL_W-1:0]  line_limit_r;
  logic [MIC_W-1:0] mic_length_r;
  logic             wr_en;
  logic [1:0]       reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_budget_r <= RETRY_BUDGET_RST;
      line_limit_r   <= LINE_LIMIT_RST;
      mic_length_r   <= MIC_LENGTH_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RETRY_BUDGET: retry_budget_r <= cfg_pwdata[MR_W-1:0];
        REG_LINE_LIMIT:   line_limit_r   <= cfg_pwdata[LL_W-1:0];
        REG_MIC_LENGTH:   mic_length_r   <= cfg_pwdata[MIC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RETRY_BUDGET: cfg_prdata = 32'(retry_budget_r);
      REG_LINE_LIMIT:   cfg_prdata = 32'(line_limit_r);
      REG_MIC_LENGTH:   cfg_prdata = 32'(mic_length_r);
      default:          cfg_prdata = 32'd0;
    endcase
  end

  assign retry_budget = retry_budget_r;
  assign line_limit   = line_limit_r;
  assign mic_length   = mic_length_r;

endmodule

FILE: rtl/core/lalc_datapath.sv
// Datapath: line buffers, frame length, frame byte streaming and the result register.
// Depends on lalc_pkg; driven by commands from lalc_ctrl.
module lalc_datapath #(
  parameter int MAX_LINE = lalc_pkg::MAX_LINE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [7:0]                 serial_byte,
  input  logic [lalc_pkg::LL_W-1:0]  line_limit,
  input  logic [lalc_pkg::MIC_W-1:0] mic_length,
  input  lalc_pkg::dp_cmd_t          cmd,
  output lalc_pkg::dp_stat_t         stat,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [15:0]                out_tdata,  // radio_cmd, nack, deliver_rx, frame_byte, pad
  output logic [0:0]                 out_tuser,  // frame_valid
  output logic                       out_tlast
);
  import lalc_pkg::*;

  localparam int IW = $clog2(MAX_LINE);
  localparam int CW = $clog2(MAX_LINE + 1);
  localparam int KW = $clog2(MAX_LINE + 2);

  // Two line banks: one collects serial bytes while the other holds the frame payload.
  // Completing a line swaps the banks instead of copying.
  logic [7:0]    mem_r [2][MAX_LINE];
  logic          line_bank_r;
  logic [CW-1:0] line_count_r;
  logic [CW-1:0] frame_count_r;
  logic [7:0]    frame_length_r;
  logic [7:0]    rd_q_r;
  logic [CW-1:0] pay_idx_r, pay_idx_nxt;
  logic [KW-1:0] pos_r, pos_nxt;

  logic [CW-1:0] count_eff, count_inc;
  logic [LL_W:0] limit_eff;
  logic          line_done;

  logic          out_valid_r;
  radio_cmd_t    out_cmd_r;
  logic          out_nack_r, out_deliver_r, out_fvalid_r, out_last_r;
  logic [7:0]    out_byte_r;
  logic [7:0]    stream_byte;
  logic          stream_last;
  logic          out_free;

  always_comb begin
    count_eff = (line_count_r >= CW'(MAX_LINE)) ? '0 : line_count_r;
    count_inc = count_eff + CW'(1);
    if (line_limit == '0 || (LL_W+1)'(line_limit) > (LL_W+1)'(MAX_LINE)) begin
      limit_eff = (LL_W+1)'(MAX_LINE);
    end else begin
      limit_eff = (LL_W+1)'(line_limit);
    end
    line_done = (serial_byte == CR_CHAR) || ((LL_W+1)'(count_inc) >= limit_eff);
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      mem_r[line_bank_r][count_eff[IW-1:0]] <= serial_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_bank_r    <= 1'b0;
      line_count_r   <= '0;
      frame_count_r  <= '0;
      frame_length_r <= '0;
    end else if (cmd.take_byte) begin
      if (line_done) begin
        line_bank_r    <= ~line_bank_r;
        line_count_r   <= '0;
        frame_count_r  <= count_inc;
        frame_length_r <= 8'(count_inc) + 8'(mic_length);
      end else begin
        line_count_r <= count_inc;
      end
    end
  end

  // The read register always holds the payload byte at pay_idx_r.
  always_comb begin
    pos_nxt     = pos_r;
    pay_idx_nxt = pay_idx_r;
    if (cmd.stream_start) begin
      pos_nxt     = '0;
      pay_idx_nxt = '0;
    end else if (cmd.load_stream) begin
      pos_nxt = pos_r + KW'(1);
      if (pos_r >= KW'(2)) begin
        pay_idx_nxt = pay_idx_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_q_r <= mem_r[~line_bank_r][pay_idx_nxt[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      pay_idx_r <= '0;
    end else begin
      pos_r     <= pos_nxt;
      pay_idx_r <= pay_idx_nxt;
    end
  end

  always_comb begin
    if (pos_r == KW'(0)) begin
      stream_byte = FRAME_HEADER;
    end else if (pos_r == KW'(1)) begin
      stream_byte = frame_length_r;
    end else begin
      stream_byte = rd_q_r;
    end
    stream_last = (pos_r == KW'(frame_count_r) + KW'(1));
  end

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_one || cmd.load_stream) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_one) begin
      out_cmd_r     <= cmd.res_cmd;
      out_nack_r    <= cmd.res_nack;
      out_deliver_r <= cmd.res_deliver;
      out_byte_r    <= 8'd0;
      out_fvalid_r  <= 1'b0;
      out_last_r    <= 1'b1;
    end else if (cmd.load_stream) begin
      out_cmd_r     <= CMD_SEND;
      out_nack_r    <= 1'b0;
      out_deliver_r <= 1'b0;
      out_byte_r    <= stream_byte;
      out_fvalid_r  <= 1'b1;
      out_last_r    <= stream_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_byte_r, out_deliver_r, out_nack_r, out_cmd_r};
  assign out_tuser  = out_fvalid_r;
  assign out_tlast  = out_last_r;

  assign stat.out_free    = out_free;
  assign stat.stream_last = stream_last;
  assign stat.line_done   = line_done;

endmodule

FILE: rtl/core/lalc_ctrl.sv
// Controller: event decode, stop-and-wait ARQ state and result sequencing.
// Depends on lalc_pkg; commands lalc_datapath through dp_cmd_t.
module lalc_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [2:0]                req_type,
  input  logic [7:0]                ack_marker,
  input  logic [lalc_pkg::MR_W-1:0] retry_budget,
  input  lalc_pkg::dp_stat_t        stat,
  output lalc_pkg::dp_cmd_t         cmd
);
  import lalc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ONE,
    ST_STREAM
  } state_t;

  state_t          state_r, state_nxt;
  logic            line_ready_r, line_ready_nxt;
  logic            sending_r, sending_nxt;
  logic            waiting_r, waiting_nxt;
  logic            failed_r, failed_nxt;
  logic [MR_W-1:0] retries_r, retries_nxt;
  radio_cmd_t      res_cmd_r, res_cmd_nxt;
  logic            res_nack_r, res_nack_nxt;
  logic            res_deliver_r, res_deliver_nxt;
  logic            radio_event;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt       = state_r;
    line_ready_nxt  = line_ready_r;
    sending_nxt     = sending_r;
    waiting_nxt     = waiting_r;
    failed_nxt      = failed_r;
    retries_nxt     = retries_r;
    res_cmd_nxt     = res_cmd_r;
    res_nack_nxt    = res_nack_r;
    res_deliver_nxt = res_deliver_r;
    radio_event     = 1'b0;
    cmd             = '0;
    cmd.res_cmd     = res_cmd_r;
    cmd.res_nack    = res_nack_r;
    cmd.res_deliver = res_deliver_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt       = ST_ONE;
          res_cmd_nxt     = CMD_NONE;
          res_nack_nxt    = 1'b0;
          res_deliver_nxt = 1'b0;
          unique case (req_type)
            REQ_BYTE: begin
              cmd.take_byte = 1'b1;
              if (stat.line_done) begin
                line_ready_nxt = 1'b1;
              end
            end
            REQ_TICK: begin
              if (!sending_r && line_ready_r) begin
                line_ready_nxt = 1'b0;
                retries_nxt    = retry_budget;
                sending_nxt    = 1'b1;
              end
              if (failed_r) begin
                failed_nxt   = 1'b0;
                res_nack_nxt = 1'b1;
              end
            end
            REQ_RX_OK: begin
              if (ack_marker == 8'd0) begin
                res_deliver_nxt = 1'b1;
              end else begin
                sending_nxt = 1'b0;
                waiting_nxt = 1'b0;
                res_cmd_nxt = CMD_LISTEN;
              end
            end
            REQ_RX_FAIL: begin
              radio_event = 1'b1;
              if (waiting_r) begin
                if (retries_r != '0) begin
                  retries_nxt = retries_r - MR_W'(1);
                end
                // An exhausted budget fails the frame and stops sending.
                if (retries_nxt == '0) begin
                  failed_nxt  = 1'b1;
                  waiting_nxt = 1'b0;
                  sending_nxt = 1'b0;
                end
              end
            end
            REQ_TX_DONE: begin
              radio_event = 1'b1;
            end
            default: ;
          endcase

          if (radio_event) begin
            if (!sending_nxt) begin
              res_cmd_nxt = CMD_LISTEN;
            end else begin
              waiting_nxt      = 1'b1;
              res_cmd_nxt      = CMD_SEND;
              state_nxt        = ST_STREAM;
              cmd.stream_start = 1'b1;
            end
          end
        end
      end
      ST_ONE: begin
        if (stat.out_free) begin
          cmd.load_one = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_STREAM: begin
        if (stat.out_free) begin
          cmd.load_stream = 1'b1;
          if (stat.stream_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      line_ready_r  <= 1'b0;
      sending_r     <= 1'b0;
      waiting_r     <= 1'b0;
      failed_r      <= 1'b0;
      retries_r     <= '0;
      res_cmd_r     <= CMD_NONE;
      res_nack_r    <= 1'b0;
      res_deliver_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      line_ready_r  <= line_ready_nxt;
      sending_r     <= sending_nxt;
      waiting_r     <= waiting_nxt;
      failed_r      <= failed_nxt;
      retries_r     <= retries_nxt;
      res_cmd_r     <= res_cmd_nxt;
      res_nack_r    <= res_nack_nxt;
      res_deliver_r <= res_deliver_nxt;
    end
  end

endmodule

FILE: rtl/core/line_assembler_arq_link_controller.sv
// Line assembler with a stop-and-wait ARQ link controller. Serial bytes build a
// line that ends at carriage return or at line_limit (MAX_LINE when line_limit is
// zero or above MAX_LINE); poll ticks and radio events drive sending with a retry
// budget. One input event is taken at a time. An event that gives a single result
// passes through ST_ONE, which loads the result register once it is free, and
// the next event is taken after that load.
// A send command streams 2 + N frame bytes (N payload bytes, at most MAX_LINE)
// one per cycle while out_tready holds; the single result register carries each
// frame byte.
// The line buffer needs no clearing after reset. Depends on lalc_pkg, lalc_cfg,
// lalc_ctrl and lalc_datapath.
module line_assembler_arq_link_controller #(
  parameter int MAX_LINE = lalc_pkg::MAX_LINE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // serial_byte, ack_marker
  input  logic [2:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // radio_cmd, nack, deliver_rx, frame_byte, pad
  output logic [0:0]  out_tuser,  // frame_valid
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lalc_pkg::*;

  logic [MR_W-1:0]  retry_budget;
  logic [LL_W-1:0]  line_limit;
  logic [MIC_W-1:0] mic_length;
  dp_cmd_t          dp_cmd;
  dp_stat_t         dp_stat;

  lalc_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .retry_budget (retry_budget),
    .line_limit   (line_limit),
    .mic_length   (mic_length)
  );

  lalc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .req_type     (in_tuser),
    .ack_marker   (in_tdata[15:8]),
    .retry_budget (retry_budget),
    .stat         (dp_stat),
    .cmd          (dp_cmd)
  );

  lalc_datapath #(
    .MAX_LINE (MAX_LINE)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .serial_byte (in_tdata[7:0]),
    .line_limit  (line_limit),
    .mic_length  (mic_length),
    .cmd         (dp_cmd),
    .stat        (dp_stat),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule
